### rtl/timer_expiry_queue_defines.svh
// ----------------------------------------------------------------------------
// timer expiry queue assertion macros
// concurrent check helpers, empty when building for synthesis
// ----------------------------------------------------------------------------
`ifndef TIMER_EXPIRY_QUEUE_DEFINES_SVH
`define TIMER_EXPIRY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clock, off during reset
`define TEQ_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timer_expiry_queue: check failed");
// next-cycle implication
`define TEQ_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timer_expiry_queue: check failed");
`else
`define TEQ_ASSERT_IMP(name, ante, cons)
`define TEQ_ASSERT_NXT(name, ante, cons)
`endif

`endif

### rtl/tqe_pkg.sv
// ----------------------------------------------------------------------------
// tqe_pkg
// shared constants, codes and interface structs of the timer expiry queue
// ----------------------------------------------------------------------------
package tqe_pkg;

   localparam int NUM_SLOTS  = 16;
   localparam int SLOT_W     = 4;
   // slot fields are four bits wide, so at most sixteen slots are usable
   localparam int USED_SLOTS = (NUM_SLOTS < (1 << SLOT_W)) ? NUM_SLOTS : (1 << SLOT_W);
   localparam int SIDX_W     = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;

   localparam int DL_W       = 48;
   localparam int IV_W       = 32;
   localparam int RAM_W      = DL_W + IV_W;
   localparam int MIN_DLY_W  = 20;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 3;

   localparam logic [MIN_DLY_W-1:0] MIN_DELAY_RST = MIN_DLY_W'(100);

   localparam int REQ_TUSER_W = OP_W;
   localparam int REQ_TDATA_W = 136;
   localparam int RSP_TUSER_W = STATUS_W + 1;
   localparam int RSP_TDATA_W = 104;

   // request kinds
   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_TIMER  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd4;

   // control into the slot scanner
   typedef struct packed {
      logic                  start;
      logic                  use_now;
      logic [USED_SLOTS-1:0] sel;
      logic [DL_W-1:0]       now;
   } scan_ctl_type;

   // scanner outcome, stable once busy drops
   typedef struct packed {
      logic                  busy;
      logic                  found;
      logic [SIDX_W-1:0]     idx;
      logic [DL_W-1:0]       dl;
      logic [IV_W-1:0]       iv;
      logic [USED_SLOTS-1:0] hit;
   } scan_res_type;

endpackage

### rtl/tqe_ram.sv
// ----------------------------------------------------------------------------
// tqe_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tqe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/tqe_scan.sv
// ----------------------------------------------------------------------------
// tqe_scan
// walks every slot of the memory once and keeps the earliest selected deadline
// ----------------------------------------------------------------------------
module tqe_scan (
   input  logic                         clock,
   input  logic                         reset,
   input  tqe_pkg::scan_ctl_type        ctl,
   output logic                         rd_en,
   output logic [tqe_pkg::SIDX_W-1:0]   rd_addr,
   input  logic [tqe_pkg::RAM_W-1:0]    rd_data,
   output tqe_pkg::scan_res_type        res
);
   import tqe_pkg::*;

   localparam logic [SIDX_W-1:0] LAST_IDX = SIDX_W'(USED_SLOTS - 1);

   logic                  issue_ff, issue_in;
   logic [SIDX_W-1:0]     cnt_ff, cnt_in;
   logic                  dvld_ff, dvld_in;
   logic [SIDX_W-1:0]     didx_ff, didx_in;
   logic                  found_ff, found_in;
   logic [SIDX_W-1:0]     idx_ff, idx_in;
   logic [DL_W-1:0]       dl_ff, dl_in;
   logic [IV_W-1:0]       iv_ff, iv_in;
   logic [USED_SLOTS-1:0] hit_ff, hit_in;

   logic [DL_W-1:0] rd_dl;
   logic [IV_W-1:0] rd_iv;
   logic            cand;
   logic            better;

   assign rd_dl  = rd_data[DL_W-1:0];
   assign rd_iv  = rd_data[RAM_W-1:DL_W];
   assign cand   = dvld_ff && ctl.sel[didx_ff] && (!ctl.use_now || (rd_dl <= ctl.now));
   // strict compare keeps the lower slot on equal deadlines
   assign better = !found_ff || (rd_dl < dl_ff);

   always_comb begin
      issue_in = issue_ff;
      cnt_in   = cnt_ff;
      dvld_in  = issue_ff;
      didx_in  = cnt_ff;
      found_in = found_ff;
      idx_in   = idx_ff;
      dl_in    = dl_ff;
      iv_in    = iv_ff;
      hit_in   = hit_ff;
      if (ctl.start) begin
         issue_in = 1'b1;
         cnt_in   = '0;
         found_in = 1'b0;
         hit_in   = '0;
      end else if (issue_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_IDX) begin
            issue_in = 1'b0;
         end
      end
      if (cand) begin
         hit_in[didx_ff] = 1'b1;
         if (better) begin
            found_in = 1'b1;
            idx_in   = didx_ff;
            dl_in    = rd_dl;
            iv_in    = rd_iv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         dvld_ff  <= 1'b0;
         found_ff <= 1'b0;
         hit_ff   <= '0;
      end else begin
         issue_ff <= issue_in;
         dvld_ff  <= dvld_in;
         found_ff <= found_in;
         hit_ff   <= hit_in;
      end
      cnt_ff  <= cnt_in;
      didx_ff <= didx_in;
      idx_ff  <= idx_in;
      dl_ff   <= dl_in;
      iv_ff   <= iv_in;
   end

   assign rd_en   = issue_ff;
   assign rd_addr = cnt_ff;

   always_comb begin
      res.busy  = ctl.start | issue_ff | dvld_ff;
      res.found = found_ff;
      res.idx   = idx_ff;
      res.dl    = dl_ff;
      res.iv    = iv_ff;
      res.hit   = hit_ff;
   end

endmodule

### rtl/timer_expiry_queue.sv
// ----------------------------------------------------------------------------
// timer_expiry_queue
// timer slots ordered by deadline: add, cancel and tick with in-order expiry
// ----------------------------------------------------------------------------
//
// channel   dir  handshake            payload
// req_      in   tvalid/tready        tuser opcode, tdata slot/deadline/interval/now
// rsp_      out  tvalid/tready/tlast  tuser status/expired, tdata slot/flags/next
// csr_      in   wr_en                min_delay (20 bits)
//
// every pass over the slot memory reads each slot once (one read a cycle
// through the memory read port, whose read data is registered)
// add and cancel: one pass; tick: 2 passes with nothing expired, otherwise
// (expired + 1) passes and one result per expired slot
// reset clears the armed bits, the control state and min_delay (back to 100);
// slot memory contents need no clearing pass
// a new request is taken once the previous one has loaded its last result;
// a stalled result waits in the output register without holding up the next request
//
`include "timer_expiry_queue_defines.svh"

module timer_expiry_queue (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_wr_en,
   input  logic [tqe_pkg::MIN_DLY_W-1:0]     csr_wr_data,    // min_delay
   // requests
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tqe_pkg::REQ_TUSER_W-1:0]   req_tuser,      // [1:0] opcode
   input  logic [tqe_pkg::REQ_TDATA_W-1:0]   req_tdata,      // [3:0] target_slot,
                                                             // [51:4] deadline,
                                                             // [83:52] repeat_interval,
                                                             // [131:84] current_time
   // results
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic                              rsp_tlast,
   output logic [tqe_pkg::RSP_TUSER_W-1:0]   rsp_tuser,      // [2:0] status,
                                                             // [3] expired_valid
   output logic [tqe_pkg::RSP_TDATA_W-1:0]   rsp_tdata       // [3:0] slot,
                                                             // [4] earliest_changed,
                                                             // [5] next_valid,
                                                             // [53:6] next_deadline,
                                                             // [101:54] next_delay
);
   import tqe_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_ADD_FIN = 3'd2;
   localparam logic [2:0] S_PICK    = 3'd3;
   localparam logic [2:0] S_OUT     = 3'd4;

   // what the running pass is for
   localparam logic [1:0] PH_ADD    = 2'd0;
   localparam logic [1:0] PH_TFIRST = 2'd1;
   localparam logic [1:0] PH_TICK   = 2'd2;
   localparam logic [1:0] PH_FINAL  = 2'd3;

   // request fields
   logic [OP_W-1:0]   in_op;
   logic [SLOT_W-1:0] in_tgt;
   logic [DL_W-1:0]   in_dl;
   logic [IV_W-1:0]   in_iv;
   logic [DL_W-1:0]   in_now;

   assign in_op  = req_tuser[1:0];
   assign in_tgt = req_tdata[3:0];
   assign in_dl  = req_tdata[51:4];
   assign in_iv  = req_tdata[83:52];
   assign in_now = req_tdata[131:84];

   // control state
   logic [2:0]            state_ff, state_in;
   logic [1:0]            phase_ff, phase_in;
   logic                  start_ff, start_in;
   logic [USED_SLOTS-1:0] armed_ff, armed_in;
   logic [USED_SLOTS-1:0] pending_ff, pending_in;
   logic [MIN_DLY_W-1:0]  min_delay_ff, min_delay_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // request payload held for the whole operation
   logic [DL_W-1:0]       dl_ff, dl_in;
   logic [IV_W-1:0]       iv_ff, iv_in;
   logic [DL_W-1:0]       now_ff, now_in;

   // fields of the closing result
   logic [SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic                  res_ev_ff, res_ev_in;
   logic                  res_ec_ff, res_ec_in;
   logic                  nxt_valid_ff, nxt_valid_in;
   logic [DL_W-1:0]       nxt_dl_ff, nxt_dl_in;

   // output register
   logic [SLOT_W-1:0]     o_slot_ff, o_slot_in;
   logic [STATUS_W-1:0]   o_status_ff, o_status_in;
   logic                  o_ev_ff, o_ev_in;
   logic                  o_ec_ff, o_ec_in;
   logic                  o_nv_ff, o_nv_in;
   logic [DL_W-1:0]       o_nd_ff, o_nd_in;
   logic [DL_W-1:0]       o_delay_ff, o_delay_in;
   logic                  o_last_ff, o_last_in;

   // slot memory: {interval, deadline}
   logic                  ram_we;
   logic [SIDX_W-1:0]     ram_waddr;
   logic [RAM_W-1:0]      ram_wdata;
   logic                  ram_re;
   logic [SIDX_W-1:0]     ram_raddr;
   logic [RAM_W-1:0]      ram_rdata;

   scan_ctl_type          scan_ctl;
   scan_res_type          scan_res;

   tqe_ram #(
      .WIDTH (RAM_W),
      .DEPTH (USED_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // first tick pass tests deadline <= now, later tick passes walk the pending set
   always_comb begin
      scan_ctl.start   = start_ff;
      scan_ctl.use_now = (phase_ff == PH_TFIRST);
      scan_ctl.sel     = (phase_ff == PH_TICK) ? pending_ff : armed_ff;
      scan_ctl.now     = now_ff;
   end

   tqe_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctl     (scan_ctl),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata),
      .res     (scan_res)
   );

   // lowest free slot
   logic              free_ok;
   logic [SIDX_W-1:0] free_idx;

   always_comb begin
      free_ok  = 1'b0;
      free_idx = '0;
      for (int i = USED_SLOTS - 1; i >= 0; i--) begin
         if (!armed_ff[i]) begin
            free_ok  = 1'b1;
            free_idx = SIDX_W'(i);
         end
      end
   end

   // cancel target lookup
   logic tgt_ok;
   logic tgt_armed;

   assign tgt_ok    = ({1'b0, in_tgt} < (SLOT_W + 1)'(USED_SLOTS));
   assign tgt_armed = tgt_ok && armed_ff[in_tgt[SIDX_W-1:0]];

   // expiry bookkeeping for the slot just picked
   logic [USED_SLOTS-1:0] pick_src;
   logic [USED_SLOTS-1:0] pick_rest;
   logic [DL_W:0]         reload_sum;
   logic [DL_W-1:0]       reload_dl;

   assign pick_src   = (phase_ff == PH_TFIRST) ? scan_res.hit : pending_ff;
   assign pick_rest  = pick_src & ~(USED_SLOTS'(1) << scan_res.idx);
   assign reload_sum = (DL_W + 1)'(now_ff) + (DL_W + 1)'(scan_res.iv);
   // reload saturates at the top of the 48-bit time range
   assign reload_dl  = reload_sum[DL_W] ? {DL_W{1'b1}} : reload_sum[DL_W-1:0];

   // add: did the new deadline become the earliest
   logic add_earlier;
   assign add_earlier = !scan_res.found || (dl_ff < scan_res.dl);

   // delay to the next deadline, floored at min_delay
   logic [DL_W-1:0] delay_raw;
   logic [DL_W-1:0] delay_min;
   logic [DL_W-1:0] delay_out;

   assign delay_raw = (nxt_dl_ff > now_ff) ? (nxt_dl_ff - now_ff) : '0;
   assign delay_min = DL_W'(min_delay_ff);
   assign delay_out = (delay_raw < delay_min) ? delay_min : delay_raw;

   logic can_load;
   assign can_load   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      start_in      = 1'b0;
      armed_in      = armed_ff;
      pending_in    = pending_ff;
      min_delay_in  = csr_wr_en ? csr_wr_data : min_delay_ff;
      dl_in         = dl_ff;
      iv_in         = iv_ff;
      now_in        = now_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      res_ev_in     = res_ev_ff;
      res_ec_in     = res_ec_ff;
      nxt_valid_in  = nxt_valid_ff;
      nxt_dl_in     = nxt_dl_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      o_slot_in     = o_slot_ff;
      o_status_in   = o_status_ff;
      o_ev_in       = o_ev_ff;
      o_ec_in       = o_ec_ff;
      o_nv_in       = o_nv_ff;
      o_nd_in       = o_nd_ff;
      o_delay_in    = o_delay_ff;
      o_last_in     = o_last_ff;
      ram_we        = 1'b0;
      ram_waddr     = free_idx;
      ram_wdata     = {iv_ff, dl_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               dl_in  = in_dl;
               iv_in  = in_iv;
               now_in = in_now;
               case (in_op)
                  OP_ADD: begin
                     phase_in = PH_ADD;
                     start_in = 1'b1;
                     state_in = S_SCAN;
                  end
                  OP_CANCEL: begin
                     res_slot_in   = in_tgt;
                     res_status_in = tgt_armed ? ST_CANCELLED : ST_NO_TIMER;
                     res_ev_in     = 1'b0;
                     res_ec_in     = 1'b0;
                     if (tgt_armed) begin
                        armed_in[in_tgt[SIDX_W-1:0]] = 1'b0;
                     end
                     phase_in = PH_FINAL;
                     start_in = 1'b1;
                     state_in = S_SCAN;
                  end
                  OP_TICK: begin
                     phase_in = PH_TFIRST;
                     start_in = 1'b1;
                     state_in = S_SCAN;
                  end
                  default: begin
                     // unused opcode: dropped without a result
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (!scan_res.busy) begin
               case (phase_ff)
                  PH_ADD: begin
                     state_in = S_ADD_FIN;
                  end
                  PH_TFIRST, PH_TICK: begin
                     if (scan_res.found) begin
                        state_in = S_PICK;
                     end else begin
                        // nothing expired
                        res_slot_in   = '0;
                        res_status_in = ST_EXPIRED;
                        res_ev_in     = 1'b0;
                        res_ec_in     = 1'b0;
                        phase_in      = PH_FINAL;
                        start_in      = 1'b1;
                     end
                  end
                  default: begin
                     nxt_valid_in = scan_res.found;
                     nxt_dl_in    = scan_res.found ? scan_res.dl : '0;
                     state_in     = S_OUT;
                  end
               endcase
            end
         end

         S_ADD_FIN: begin
            if (free_ok) begin
               ram_we                = 1'b1;
               armed_in[free_idx]    = 1'b1;
               res_slot_in           = SLOT_W'(free_idx);
               res_status_in         = ST_ADDED;
               res_ec_in             = add_earlier;
               nxt_valid_in          = 1'b1;
               nxt_dl_in             = add_earlier ? dl_ff : scan_res.dl;
            end else begin
               res_slot_in   = '0;
               res_status_in = ST_FULL;
               res_ec_in     = 1'b0;
               nxt_valid_in  = scan_res.found;
               nxt_dl_in     = scan_res.found ? scan_res.dl : '0;
            end
            res_ev_in = 1'b0;
            state_in  = S_OUT;
         end

         S_PICK: begin
            if ((pick_rest == '0) || can_load) begin
               ram_waddr = scan_res.idx;
               ram_wdata = {scan_res.iv, reload_dl};
               if (scan_res.iv != '0) begin
                  ram_we = 1'b1;
               end else begin
                  armed_in[scan_res.idx] = 1'b0;
               end
               pending_in = pick_rest;
               start_in   = 1'b1;
               state_in   = S_SCAN;
               if (pick_rest != '0) begin
                  // more expired slots follow: plain result now
                  rsp_valid_in = 1'b1;
                  o_slot_in    = SLOT_W'(scan_res.idx);
                  o_status_in  = ST_EXPIRED;
                  o_ev_in      = 1'b1;
                  o_ec_in      = 1'b0;
                  o_nv_in      = 1'b0;
                  o_nd_in      = '0;
                  o_delay_in   = '0;
                  o_last_in    = 1'b0;
                  phase_in     = PH_TICK;
               end else begin
                  // last expired slot: result closes after the next-deadline pass
                  res_slot_in   = SLOT_W'(scan_res.idx);
                  res_status_in = ST_EXPIRED;
                  res_ev_in     = 1'b1;
                  res_ec_in     = 1'b0;
                  phase_in      = PH_FINAL;
               end
            end
         end

         S_OUT: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               o_slot_in    = res_slot_ff;
               o_status_in  = res_status_ff;
               o_ev_in      = res_ev_ff;
               o_ec_in      = res_ec_ff;
               o_nv_in      = nxt_valid_ff;
               o_nd_in      = nxt_dl_ff;
               o_delay_in   = nxt_valid_ff ? delay_out : '0;
               o_last_in    = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_ADD;
         start_ff     <= 1'b0;
         armed_ff     <= '0;
         pending_ff   <= '0;
         min_delay_ff <= MIN_DELAY_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         start_ff     <= start_in;
         armed_ff     <= armed_in;
         pending_ff   <= pending_in;
         min_delay_ff <= min_delay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dl_ff         <= dl_in;
      iv_ff         <= iv_in;
      now_ff        <= now_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      res_ev_ff     <= res_ev_in;
      res_ec_ff     <= res_ec_in;
      nxt_valid_ff  <= nxt_valid_in;
      nxt_dl_ff     <= nxt_dl_in;
      o_slot_ff     <= o_slot_in;
      o_status_ff   <= o_status_in;
      o_ev_ff       <= o_ev_in;
      o_ec_ff       <= o_ec_in;
      o_nv_ff       <= o_nv_in;
      o_nd_ff       <= o_nd_in;
      o_delay_ff    <= o_delay_in;
      o_last_ff     <= o_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tuser  = {o_ev_ff, o_status_ff};
   assign rsp_tdata  = {2'b00, o_delay_ff, o_nd_ff, o_nv_ff, o_ec_ff, o_slot_ff};

   // checks

   // no memory write may land under a running pass
   `TEQ_ASSERT_IMP(a_no_write_during_scan, ram_we, !scan_res.busy)
   // expired set only holds slots that are still armed
   `TEQ_ASSERT_IMP(a_pending_armed, state_ff != S_IDLE, (pending_ff & ~armed_ff) == '0)
   // every result before the last one names an expired slot
   `TEQ_ASSERT_IMP(a_nonlast_expired, rsp_valid_ff && !o_last_ff,
                   o_ev_ff && (o_status_ff == ST_EXPIRED))
   // a started pass really runs
   `TEQ_ASSERT_NXT(a_scan_runs, start_ff, scan_res.busy)

endmodule
